@@ design/keypad_chord_decoder_top_assert.svh @@
// Assertion macros for the keypad chord decoder checker.
`ifndef KEYPAD_CHORD_DECODER_TOP_ASSERT_SVH
`define KEYPAD_CHORD_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define KCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/kcd_pkg.sv @@
// Package with key codes, matrix bit positions and state types for the chord decoder.
`default_nettype none
package kcd_pkg;

    typedef logic [6:0] t_code;

    typedef struct packed {
        logic prev_minus_down;
        logic prev_zero_down;
        logic minus_used;
        logic zero_used;
        logic fn_active;
        logic fn_combo_seen;
        logic fn_slash_latch;
        logic fn_clear_latch;
        logic minus_slash_latch;
        logic minus_star_latch;
    } t_flags;

    localparam int BIT_CLEAR = 0;
    localparam int BIT_SLASH = 1;
    localparam int BIT_STAR  = 2;
    localparam int BIT_MINUS = 3;
    localparam int BIT_EIGHT = 5;
    localparam int BIT_FIVE  = 9;
    localparam int BIT_TWO   = 13;
    localparam int BIT_ZERO  = 15;

    // keys 7 9 + 4 6 . 1 3
    localparam logic [15:0] PLAIN_MASK = 16'h5DD0;

    localparam t_code CODE_NONE  = 7'h00;
    localparam t_code CODE_T     = 7'h54;
    localparam t_code CODE_A     = 7'h41;
    localparam t_code CODE_M     = 7'h4D;
    localparam t_code CODE_EQ    = 7'h3D;
    localparam t_code CODE_MINUS = 7'h2D;
    localparam t_code CODE_ZERO  = 7'h30;
    localparam t_code CODE_EIGHT = 7'h38;
    localparam t_code CODE_TWO   = 7'h32;
    localparam t_code CODE_FIVE  = 7'h35;
    localparam t_code CODE_SLASH = 7'h2F;
    localparam t_code CODE_STAR  = 7'h2A;
    localparam t_code CODE_CLEAR = 7'h43;

    // row-major: C / * -, 7 8 9 +, 4 5 6 ., 1 2 3 0
    localparam t_code KEYMAP [16] = '{
        7'h43, 7'h2F, 7'h2A, 7'h2D, 7'h37, 7'h38, 7'h39, 7'h2B,
        7'h34, 7'h35, 7'h36, 7'h2E, 7'h31, 7'h32, 7'h33, 7'h30
    };

endpackage
`default_nettype wire

@@ design/kcd_decode.sv @@
// Combinational scan decoder: one matrix scan against the chord flags.
`default_nettype none
module kcd_decode (
    input  wire logic [15:0]    i_matrix,
    input  wire logic           i_numpad,
    input  wire logic           i_idle,
    input  wire kcd_pkg::t_flags i_flags,
    output kcd_pkg::t_code      o_code,
    output kcd_pkg::t_flags     o_flags
);
    import kcd_pkg::*;

    logic  minus, zero, eight, two, five, slash, star, clr;
    logic  fn, minus_rel, zero_rel, done, tap, solo;
    t_code plain, code;
    t_flags n;

    assign minus = i_matrix[BIT_MINUS];
    assign zero  = i_matrix[BIT_ZERO];
    assign eight = i_matrix[BIT_EIGHT];
    assign two   = i_matrix[BIT_TWO];
    assign five  = i_matrix[BIT_FIVE];
    assign slash = i_matrix[BIT_SLASH];
    assign star  = i_matrix[BIT_STAR];
    assign clr   = i_matrix[BIT_CLEAR];

    // last plain key in row-major order wins
    always_comb begin
        plain = CODE_NONE;
        for (int i = 0; i < 16; i++) begin
            if (PLAIN_MASK[i] && i_matrix[i]) begin
                plain = KEYMAP[i];
            end
        end
    end

    always_comb begin
        n         = i_flags;
        code      = CODE_NONE;
        done      = 1'b0;
        tap       = 1'b0;
        solo      = 1'b0;
        fn        = minus && zero;
        minus_rel = i_flags.prev_minus_down && !minus;
        zero_rel  = i_flags.prev_zero_down && !zero;
        n.prev_minus_down = minus;
        n.prev_zero_down  = zero;

        if (fn) begin
            n.minus_used = 1'b1;
            n.zero_used  = 1'b1;
            if (!i_flags.fn_active) begin
                n.fn_active     = 1'b1;
                n.fn_combo_seen = 1'b0;
            end
            if (slash || star || clr || five || eight || two || (plain != CODE_NONE)) begin
                n.fn_combo_seen = 1'b1;
            end
        end

        if (fn && slash && !i_flags.fn_slash_latch) begin
            n.fn_slash_latch = 1'b1;
            code = CODE_T;
            done = 1'b1;
        end

        if (!done) begin
            if (!slash) n.fn_slash_latch = 1'b0;
            if (fn && clr && !i_flags.fn_clear_latch) begin
                n.fn_clear_latch = 1'b1;
                code = CODE_A;
                done = 1'b1;
            end
        end

        // chord release: swallow any minus/zero release in this scan
        if (!done) begin
            if (!clr) n.fn_clear_latch = 1'b0;
            if (!fn && i_flags.fn_active) begin
                tap             = !n.fn_combo_seen;
                n.fn_active     = 1'b0;
                n.fn_combo_seen = 1'b0;
                if (minus_rel) n.minus_used = 1'b0;
                if (zero_rel) n.zero_used = 1'b0;
                code = (tap && i_idle) ? CODE_M : CODE_NONE;
                done = 1'b1;
            end
        end

        if (!done) begin
            if (minus && slash && !i_flags.minus_slash_latch) begin
                n.minus_slash_latch = 1'b1;
                n.minus_used        = 1'b1;
                code = CODE_T;
                done = 1'b1;
            end
        end

        if (!done) begin
            if (!minus || !slash) n.minus_slash_latch = 1'b0;
            if (!i_numpad && minus && star && !i_flags.minus_star_latch) begin
                n.minus_star_latch = 1'b1;
                n.minus_used       = 1'b1;
                code = CODE_A;
                done = 1'b1;
            end
        end

        if (!done) begin
            if (!minus || !star) n.minus_star_latch = 1'b0;
            if (minus_rel) begin
                solo         = !n.minus_used;
                n.minus_used = 1'b0;
                if (solo) begin
                    code = CODE_MINUS;
                    done = 1'b1;
                end
            end
        end

        if (!done) begin
            if (zero_rel) begin
                solo        = !n.zero_used;
                n.zero_used = 1'b0;
                if (solo) begin
                    code = CODE_ZERO;
                    done = 1'b1;
                end
            end
        end

        if (!done) begin
            priority if (eight)          code = CODE_EIGHT;
            else if (two)                code = CODE_TWO;
            else if (five)               code = CODE_FIVE;
            else if (slash && !minus)    code = CODE_SLASH;
            else if (star && !minus)     code = CODE_STAR;
            else if (clr)                code = CODE_CLEAR;
            else                         code = plain;
        end
    end

    assign o_code  = code;
    assign o_flags = n;

endmodule
`default_nettype wire

@@ design/keypad_chord_decoder_top.sv @@
// From input transaction to result valid: input register, then result register.
// One scan per cycle unless the output stalls; the decode is one pass over the chord flags.
// The input register advances whenever the result register is empty or being taken.
// Reset (synchronous, active low) empties both stages and clears all chord flags
// and the previous code.
`default_nettype none
module keypad_chord_decoder_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output      logic                o_stall,
    input  wire logic [15:0]         i_key_matrix,
    input  wire logic                i_wake_pressed,
    input  wire logic                i_numpad_mode,
    input  wire logic                i_menu_idle,
    output      logic                o_valid,
    input  wire logic                i_stall,
    output      kcd_pkg::t_code      o_key_code,
    output      logic                o_new_press
);
    import kcd_pkg::*;

    logic        r_s1_valid;
    logic [15:0] r_matrix;
    logic        r_wake, r_numpad, r_idle;
    t_flags      r_flags, n_flags;
    t_code       r_prev_code, n_code, dec_code;
    logic        r_out_valid, r_out_new;
    t_code       r_out_code;
    logic        s1_advance, in_take;

    assign s1_advance = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall    = r_s1_valid && !s1_advance;
    assign in_take    = i_valid && !o_stall;

    kcd_decode u_decode (
        .i_matrix (r_matrix),
        .i_numpad (r_numpad),
        .i_idle   (r_idle),
        .i_flags  (r_flags),
        .o_code   (dec_code),
        .o_flags  (n_flags)
    );

    // the wake key stands in only when the decode yields no key
    assign n_code = (dec_code == CODE_NONE && r_wake) ? CODE_EQ : dec_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
            r_prev_code <= CODE_NONE;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_advance) begin
                r_out_valid <= 1'b1;
                r_flags     <= n_flags;
                r_prev_code <= n_code;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_matrix <= i_key_matrix;
            r_wake   <= i_wake_pressed;
            r_numpad <= i_numpad_mode;
            r_idle   <= i_menu_idle;
        end
        if (s1_advance) begin
            r_out_code <= n_code;
            r_out_new  <= (n_code != CODE_NONE) && (n_code != r_prev_code);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_key_code  = r_out_code;
    assign o_new_press = r_out_new;

endmodule
`default_nettype wire

@@ design/kcd_checker.sv @@
// Port-level checker for the keypad chord decoder, bound to the top level.
`default_nettype none
`include "keypad_chord_decoder_top_assert.svh"
module kcd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [6:0] o_key_code,
    input wire logic       o_new_press
);
    // a new press always carries a key
    `KCD_ASSERT_NOW(a_new_press_nonzero, i_clk, i_rst_n, o_valid && o_new_press, o_key_code != 7'h00)

    // back-to-back transactions with the same code cannot both be new presses
    `KCD_ASSERT_NOW(a_repeat_not_new, i_clk, i_rst_n, o_valid && !i_stall && $past(o_valid && !i_stall) && o_key_code == $past(o_key_code) && $past(i_rst_n), !o_new_press)

    // a stalled result holds
    `KCD_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_key_code) && $stable(o_new_press))

endmodule

bind keypad_chord_decoder_top kcd_checker u_kcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_key_code  (o_key_code),
    .o_new_press (o_new_press)
);
`default_nettype wire

@@ bench/keypad_chord_decoder_top_test.sv @@
// Self-checking bench for the keypad chord decoder: directed scan table, then random chord traffic.
`timescale 1ns / 1ps
module keypad_chord_decoder_top_test;
    import kcd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_SCANS   = 400;   // per traffic phase
    localparam int MAX_REPORTS    = 10;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct packed {
        t_code key_code;
        logic  new_press;
    } t_scan_result;

    typedef struct packed {
        logic [15:0] matrix;
        logic        wake;
        logic        numpad;
        logic        idle;
        logic        typed;
        t_code       key_code;
        logic        new_press;
    } t_scan_row;

    localparam int SCAN_ROWS = 29;

    // Typed rows carry their own expectation; the rest are left to the decoder model.
    localparam t_scan_row SCAN_TABLE [SCAN_ROWS] = '{
        '{16'h0000, 1'b0, 1'b0, 1'b1, 1'b1, CODE_NONE, 1'b0},
        '{16'h0000, 1'b1, 1'b0, 1'b1, 1'b1, CODE_EQ,   1'b1},
        '{16'hFFFF, 1'b1, 1'b0, 1'b1, 1'b1, CODE_T,    1'b1},
        '{16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b1, CODE_A,    1'b1},
        '{16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b0, CODE_NONE, 1'b0},
        '{16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0, CODE_NONE, 1'b0},
        '{16'h0000, 1'b1, 1'b0, 1'b1, 1'b0, CODE_NONE, 1'b0},
        '{16'h0008, 1'b0, 1'b0, 1'b1, 1'b0, CODE_NONE, 1'b0},
        '{16'h0000, 1'b0, 1'b0, 1'b1, 1'b0, CODE_NONE, 1'b0},
        '{16'h8000, 1'b0, 1'b0, 1'b1, 1'b0, CODE_NONE, 1'b0},
        '{16'h0000, 1'b0, 1'b0, 1'b1, 1'b0, CODE_NONE, 1'b0},
        '{16'h8008, 1'b0, 1'b0, 1'b1, 1'b0, CODE_NONE, 1'b0},
        '{16'h0000, 1'b0, 1'b0, 1'b1, 1'b0, CODE_NONE, 1'b0},
        '{16'h8008, 1'b0, 1'b0, 1'b0, 1'b0, CODE_NONE, 1'b0},
        '{16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, CODE_NONE, 1'b0},
        '{16'h000A, 1'b0, 1'b0, 1'b1, 1'b0, CODE_NONE, 1'b0},
        '{16'h000A, 1'b0, 1'b0, 1'b1, 1'b0, CODE_NONE, 1'b0},
        '{16'h0000, 1'b0, 1'b0, 1'b1, 1'b0, CODE_NONE, 1'b0},
        '{16'h000C, 1'b0, 1'b0, 1'b1, 1'b0, CODE_NONE, 1'b0},
        '{16'h0000, 1'b0, 1'b0, 1'b1, 1'b0, CODE_NONE, 1'b0},
        '{16'h000C, 1'b0, 1'b1, 1'b1, 1'b0, CODE_NONE, 1'b0},
        '{16'h0000, 1'b0, 1'b1, 1'b1, 1'b0, CODE_NONE, 1'b0},
        '{16'h5DD0, 1'b0, 1'b0, 1'b1, 1'b0, CODE_NONE, 1'b0},
        '{16'h5DD0, 1'b0, 1'b0, 1'b1, 1'b0, CODE_NONE, 1'b0},
        '{16'h8009, 1'b0, 1'b0, 1'b1, 1'b0, CODE_NONE, 1'b0},
        '{16'h0000, 1'b0, 1'b0, 1'b1, 1'b0, CODE_NONE, 1'b0},
        '{16'h2206, 1'b0, 1'b0, 1'b1, 1'b0, CODE_NONE, 1'b0},
        '{16'h0007, 1'b0, 1'b0, 1'b1, 1'b0, CODE_NONE, 1'b0},
        '{16'h0001, 1'b1, 1'b0, 1'b1, 1'b0, CODE_NONE, 1'b0}
    };

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        o_stall;
    logic [15:0] i_key_matrix   = '0;
    logic        i_wake_pressed = 1'b0;
    logic        i_numpad_mode  = 1'b0;
    logic        i_menu_idle    = 1'b0;
    logic        o_valid;
    logic        i_stall        = 1'b0;
    t_code       o_key_code;
    logic        o_new_press;

    // expectation riding along with the scan currently offered
    logic        row_typed      = 1'b0;
    t_code       row_code       = CODE_NONE;
    logic        row_new_press  = 1'b0;

    int          send_gap_pct   = 12;
    int          recv_stall_pct = 64;
    int          fault_count    = 0;
    int          quiet_cycles   = 0;

    t_flags       chord_flags = '0;
    t_code        last_code   = CODE_NONE;
    t_scan_result pending_scans [$];

    keypad_chord_decoder_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_key_matrix   (i_key_matrix),
        .i_wake_pressed (i_wake_pressed),
        .i_numpad_mode  (i_numpad_mode),
        .i_menu_idle    (i_menu_idle),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_key_code     (o_key_code),
        .o_new_press    (o_new_press)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Decode one matrix scan against the chord flags; early returns follow key priority.
    function automatic t_code decode_matrix_scan(input logic [15:0] m, input logic numpad,
                                                 input logic idle);
        logic  minus, zero, eight, two, five, slash, star, clr;
        logic  fn, minus_rel, zero_rel, tap, solo;
        t_code plain;
        minus = m[BIT_MINUS];
        zero  = m[BIT_ZERO];
        eight = m[BIT_EIGHT];
        two   = m[BIT_TWO];
        five  = m[BIT_FIVE];
        slash = m[BIT_SLASH];
        star  = m[BIT_STAR];
        clr   = m[BIT_CLEAR];
        plain = CODE_NONE;
        for (int i = 0; i < 16; i++) begin
            if (PLAIN_MASK[i] && m[i]) plain = KEYMAP[i];
        end

        fn        = minus & zero;
        minus_rel = chord_flags.prev_minus_down & ~minus;
        zero_rel  = chord_flags.prev_zero_down & ~zero;
        chord_flags.prev_minus_down = minus;
        chord_flags.prev_zero_down  = zero;

        if (fn) begin
            chord_flags.minus_used = 1'b1;
            chord_flags.zero_used  = 1'b1;
            if (!chord_flags.fn_active) begin
                chord_flags.fn_active     = 1'b1;
                chord_flags.fn_combo_seen = 1'b0;
            end
            if (slash || star || clr || five || eight || two || plain != CODE_NONE)
                chord_flags.fn_combo_seen = 1'b1;
        end

        if (fn && slash && !chord_flags.fn_slash_latch) begin
            chord_flags.fn_slash_latch = 1'b1;
            return CODE_T;
        end
        if (!slash) chord_flags.fn_slash_latch = 1'b0;

        if (fn && clr && !chord_flags.fn_clear_latch) begin
            chord_flags.fn_clear_latch = 1'b1;
            return CODE_A;
        end
        if (!clr) chord_flags.fn_clear_latch = 1'b0;

        // function chord released: swallow the minus and zero releases
        if (!fn && chord_flags.fn_active) begin
            tap = ~chord_flags.fn_combo_seen;
            chord_flags.fn_active     = 1'b0;
            chord_flags.fn_combo_seen = 1'b0;
            if (minus_rel) chord_flags.minus_used = 1'b0;
            if (zero_rel) chord_flags.zero_used = 1'b0;
            return (tap && idle) ? CODE_M : CODE_NONE;
        end

        if (minus && slash && !chord_flags.minus_slash_latch) begin
            chord_flags.minus_slash_latch = 1'b1;
            chord_flags.minus_used        = 1'b1;
            return CODE_T;
        end
        if (!minus || !slash) chord_flags.minus_slash_latch = 1'b0;

        if (!numpad && minus && star && !chord_flags.minus_star_latch) begin
            chord_flags.minus_star_latch = 1'b1;
            chord_flags.minus_used       = 1'b1;
            return CODE_A;
        end
        if (!minus || !star) chord_flags.minus_star_latch = 1'b0;

        if (minus_rel) begin
            solo = ~chord_flags.minus_used;
            chord_flags.minus_used = 1'b0;
            if (solo) return CODE_MINUS;
        end
        if (zero_rel) begin
            solo = ~chord_flags.zero_used;
            chord_flags.zero_used = 1'b0;
            if (solo) return CODE_ZERO;
        end

        if (eight) return CODE_EIGHT;
        if (two) return CODE_TWO;
        if (five) return CODE_FIVE;
        if (slash && !minus) return CODE_SLASH;
        if (star && !minus) return CODE_STAR;
        if (clr) return CODE_CLEAR;
        return plain;
    endfunction

    function automatic t_scan_result predict_key_report(input logic [15:0] m, input logic wake,
                                                        input logic numpad, input logic idle);
        t_scan_result res;
        res.key_code = decode_matrix_scan(m, numpad, idle);
        if (res.key_code == CODE_NONE && wake) res.key_code = CODE_EQ;
        res.new_press = (res.key_code != CODE_NONE) && (res.key_code != last_code);
        last_code = res.key_code;
        return res;
    endfunction

    task automatic log_fault(input string what, input t_scan_result want);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("%0t: %s: expected code %h new_press %b, got code %h new_press %b",
                     $realtime, what, want.key_code, want.new_press, o_key_code, o_new_press);
    endtask

    // Offer one scan, idling first at the current gap rate; return once it is taken.
    task automatic offer_scan(input t_scan_row row);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_key_matrix   <= row.matrix;
        i_wake_pressed <= row.wake;
        i_numpad_mode  <= row.numpad;
        i_menu_idle    <= row.idle;
        row_typed      <= row.typed;
        row_code       <= row.key_code;
        row_new_press  <= row.new_press;
        do @(posedge i_clk); while (o_stall);
    endtask

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Predict on every accepted scan, check every accepted result.
    always @(posedge i_clk) begin
        t_scan_result want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                want = predict_key_report(i_key_matrix, i_wake_pressed, i_numpad_mode,
                                          i_menu_idle);
                if (row_typed) begin
                    want.key_code  = row_code;
                    want.new_press = row_new_press;
                end
                pending_scans.push_back(want);
            end
            if (o_valid && !i_stall) begin
                if (pending_scans.size() == 0) begin
                    log_fault("unexpected result", '0);
                end else begin
                    want = pending_scans.pop_front();
                    if (o_key_code !== want.key_code || o_new_press !== want.new_press)
                        log_fault("result mismatch", want);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_scan_row   row;
        logic [15:0] held_keys;
        int          roll;
        logic [3:0]  key_bit;
        held_keys = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (SCAN_TABLE[n]) offer_scan(SCAN_TABLE[n]);

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_gap_pct   <= 64;
                recv_stall_pct <= 12;
            end else if (phase == 2) begin
                send_gap_pct   <= 0;
                recv_stall_pct <= 0;
            end
            for (int n = 0; n < RANDOM_SCANS; n++) begin
                // mostly evolve the held keys one at a time so chords build and release
                roll = $urandom_range(99);
                if (roll < 10) begin
                    held_keys = 16'($urandom);
                end else if (roll < 25) begin
                    held_keys = '0;
                end else begin
                    case ($urandom_range(9))
                        0, 1: key_bit = 4'(BIT_MINUS);
                        2, 3: key_bit = 4'(BIT_ZERO);
                        4:    key_bit = 4'(BIT_SLASH);
                        5:    key_bit = 4'(BIT_STAR);
                        6:    key_bit = 4'(BIT_CLEAR);
                        default: key_bit = 4'($urandom_range(15));
                    endcase
                    held_keys[key_bit] = ~held_keys[key_bit];
                    if ($countones(held_keys) > 5) held_keys = '0;
                end
                row.matrix    = held_keys;
                row.wake      = ($urandom_range(3) == 0);
                row.numpad    = 1'($urandom_range(1));
                row.idle      = ($urandom_range(3) != 0);
                row.typed     = 1'b0;
                row.key_code  = CODE_NONE;
                row.new_press = 1'b0;
                offer_scan(row);
            end
        end
        i_valid   <= 1'b0;
        row_typed <= 1'b0;

        while (pending_scans.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_scans.size() != 0) fault_count++;

        if (fault_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
